>>> design/spm_pkg.sv
// Shared constants and helper functions for the four channel stereo pan mixer.
package spm_pkg;

   // Channel count and default sample width
   localparam int CHANNELS         = 4;
   localparam int CH_W             = $clog2(CHANNELS);
   localparam int SAMPLE_WIDTH_DEF = 16;

   // Packed control voltage slots
   localparam int CV_W       = 16;
   localparam int PACK_W     = 64;
   localparam int PACK_SLOTS = PACK_W / CV_W;

   // Clamped knob (0..4096) and clamped CV (0..20480) widths
   localparam int LEVEL_W = 13;
   localparam int CVC_W   = 15;
   // Knob times CV never exceeds 4096 * 20480, which stays below 2^27
   localparam int GAIN_W  = LEVEL_W + CVC_W - 1;

   localparam logic [LEVEL_W-1:0] UNITY   = 13'd4096;
   localparam logic [CVC_W-1:0]   CV_FULL = 15'd20480;

   localparam logic [CV_W-1:0] LEVEL_CV_OPEN = 16'd20480;
   localparam logic [CV_W-1:0] PAN_CV_OPEN   = 16'd0;

   // Control and status register file
   localparam int STRIP_CFG_W  = 29;
   localparam int MASTER_CFG_W = 13;
   localparam int CSR_W        = 29;
   localparam int CSR_IDX_W    = 3;
   localparam logic [CSR_IDX_W-1:0]    CSR_MASTER       = CSR_IDX_W'(CHANNELS);
   localparam logic [STRIP_CFG_W-1:0]  STRIP_CFG_RESET  = 29'd134217728;
   localparam logic [MASTER_CFG_W-1:0] MASTER_CFG_RESET = 13'd2048;

   // Rounding divider shifts: 4096 * 20480 = 5 * 2^24, 10240 = 5 * 2^11
   localparam int STRIP_SHIFT = 24;
   localparam int PAN_SHIFT   = 11;

   // Pipeline depths
   localparam int RDIV_LAT = 3;
   localparam int LANE_LAT = 2 * RDIV_LAT + 3;
   localparam int MIX_LAT  = RDIV_LAT + 3;
   localparam int RSP_LAT  = LANE_LAT + MIX_LAT;

   // Saturate a knob setting to unity
   function automatic logic [LEVEL_W-1:0] clamp_knob(input logic [15:0] knob);
      if (knob > 16'(UNITY)) begin
         return UNITY;
      end
      return knob[LEVEL_W-1:0];
   endfunction

   // Clamp a signed CV to 0..10 V
   function automatic logic [CVC_W-1:0] clamp_cv(input logic [CV_W-1:0] cv);
      if (cv[CV_W-1]) begin
         return '0;
      end
      if (cv > CV_W'(CV_FULL)) begin
         return CV_FULL;
      end
      return cv[CVC_W-1:0];
   endfunction

endpackage

>>> design/four_channel_stereo_pan_mixer.sv
// Top level of the four channel stereo pan mixer.
//
// Usage: drive one audio frame on the req_ ports and raise start; the
// request is taken at every rising edge where start is high and busy is low.
// busy never rises, so a new frame may follow in every cycle.
// Each frame yields one result on the rsp_ ports, marked by rsp_strobe for a
// single cycle, after nine register stages in each channel strip (gain
// multiply, two rounding dividers, pan multiply) and six on the master bus
// (sum, master multiply, divider, saturation).
// Throughput is one frame per cycle, set by the fully pipelined multipliers.
// The receiver cannot stall; every result must be taken when strobed.
// Gains are written on the csr_ port: index 0..3 for the channel strips
// (level in bits 15..0, pan knob in bits 28..16), index 4 for the master
// level; other indexes are ignored. Write them only while no frame is in
// flight. Synchronous reset empties the pipeline and restores level 0,
// centered pan and half master gain.
module four_channel_stereo_pan_mixer #(
   parameter int SAMPLE_WIDTH = spm_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_0,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_1,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_2,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_3,
   input  logic [spm_pkg::PACK_W-1:0]     req_level_cvs,
   input  logic [spm_pkg::PACK_W-1:0]     req_pan_cvs,
   input  logic [spm_pkg::CHANNELS-1:0]   req_present_mask,
   input  logic signed [spm_pkg::CV_W-1:0] req_master_cv,
   output logic                           rsp_strobe,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_mix_left,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_mix_right,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_strip_out_0,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_strip_out_1,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_strip_out_2,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_strip_out_3,
   input  logic                           csr_we,
   input  logic [spm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spm_pkg::CSR_W-1:0]      csr_wdata
);
   import spm_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   logic [STRIP_CFG_W-1:0]  strip_cfg_ff [CHANNELS];
   logic [MASTER_CFG_W-1:0] master_cfg_ff;
   logic                    accept;
   logic signed [SW-1:0]    sample_arr [CHANNELS];
   logic [CV_W-1:0]         level_cv [CHANNELS];
   logic [CV_W-1:0]         pan_cv [CHANNELS];
   logic [CHANNELS-1:0]     lane_vld;
   logic signed [SW-1:0]    lane_strip [CHANNELS];
   logic signed [SW+1:0]    lane_left [CHANNELS];
   logic signed [SW+1:0]    lane_right [CHANNELS];
   logic signed [SW-1:0]    strip_dly_ff [MIX_LAT][CHANNELS];

   // Every request is taken; the pipeline never backs up
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign sample_arr[0] = req_sample_0;
   assign sample_arr[1] = req_sample_1;
   assign sample_arr[2] = req_sample_2;
   assign sample_arr[3] = req_sample_3;

   // Write the register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            strip_cfg_ff[i] <= STRIP_CFG_RESET;
         end
         master_cfg_ff <= MASTER_CFG_RESET;
      end else if (csr_we) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               strip_cfg_ff[i] <= csr_wdata[STRIP_CFG_W-1:0];
            end
         end
         if (csr_index == CSR_MASTER) begin
            master_cfg_ff <= csr_wdata[MASTER_CFG_W-1:0];
         end
      end
   end

   // Channel strips
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      if (i < PACK_SLOTS) begin : g_packed
         assign level_cv[i] = req_level_cvs[CV_W*i +: CV_W];
         assign pan_cv[i]   = req_pan_cvs[CV_W*i +: CV_W];
      end else begin : g_open
         assign level_cv[i] = LEVEL_CV_OPEN;
         assign pan_cv[i]   = PAN_CV_OPEN;
      end

      spm_strip #(
         .SW (SW)
      ) u_strip (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .sample    (sample_arr[i]),
         .strip_cfg (strip_cfg_ff[i]),
         .level_cv  (level_cv[i]),
         .pan_cv    (pan_cv[i]),
         .present   (req_present_mask[i]),
         .out_valid (lane_vld[i]),
         .strip_out (lane_strip[i]),
         .left_out  (lane_left[i]),
         .right_out (lane_right[i])
      );
   end

   spm_mix #(
      .SW (SW)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .master_cfg (master_cfg_ff),
      .master_cv  (req_master_cv),
      .lane_valid (&lane_vld),
      .lane_left  (lane_left),
      .lane_right (lane_right),
      .out_valid  (rsp_strobe),
      .mix_left   (rsp_mix_left),
      .mix_right  (rsp_mix_right)
   );

   // Hold strip outputs until the master mix catches up
   always_ff @(posedge clock) begin
      strip_dly_ff[0] <= lane_strip;
      for (int s = 1; s < MIX_LAT; s++) begin
         strip_dly_ff[s] <= strip_dly_ff[s-1];
      end
   end

   assign rsp_strip_out_0 = strip_dly_ff[MIX_LAT-1][0];
   assign rsp_strip_out_1 = strip_dly_ff[MIX_LAT-1][1];
   assign rsp_strip_out_2 = strip_dly_ff[MIX_LAT-1][2];
   assign rsp_strip_out_3 = strip_dly_ff[MIX_LAT-1][3];

`ifndef SYNTHESIS
   // Every request comes out after the fixed latency
   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_LAT rsp_strobe)
      else $error("request produced no result");

   // No result without a request
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, RSP_LAT))
      else $error("result without request");

   // Absent channels give a zero strip output
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ($past(req_present_mask[0], RSP_LAT) || rsp_strip_out_0 == '0) &&
         ($past(req_present_mask[1], RSP_LAT) || rsp_strip_out_1 == '0) &&
         ($past(req_present_mask[2], RSP_LAT) || rsp_strip_out_2 == '0) &&
         ($past(req_present_mask[3], RSP_LAT) || rsp_strip_out_3 == '0))
      else $error("absent channel leaked into strip output");

   // Master level of zero silences both mixes
   a_master_mute: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(master_cfg_ff, RSP_LAT) == '0 |->
         rsp_mix_left == '0 && rsp_mix_right == '0)
      else $error("muted master gave nonzero mix");
`endif

endmodule

>>> design/spm_rdiv5.sv
// Pipelined signed divide by 5 * 2^SHIFT, rounding half away from zero.
module spm_rdiv5 #(
   parameter int IN_W  = 44,
   parameter int SHIFT = 24,
   parameter int OUT_W = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [IN_W-1:0]  in_value,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_value
);
   import spm_pkg::*;

   localparam int SUM_W = IN_W + 1;
   localparam int T_W   = SUM_W - SHIFT;
   localparam int RCP_W = T_W + 1;
   localparam int MUL_W = T_W + RCP_W;
   localparam int Q_W   = T_W - 2;
   // Reciprocal of 5, exact for every quotient input below 2^T_W
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((64'd1 << (T_W + 3)) / 64'd5) + 64'd1);
   localparam logic [SUM_W-1:0] HALF = SUM_W'(64'd5 << (SHIFT - 1));

   logic [RDIV_LAT-1:0]     vld_ff;
   logic [RDIV_LAT-2:0]     neg_ff;
   logic [SUM_W-1:0]        ext;
   logic [SUM_W-1:0]        mag;
   logic [SUM_W-1:0]        rnd;
   logic [T_W-1:0]          tq_in;
   logic [T_W-1:0]          tq_ff;
   logic [MUL_W-1:0]        mul;
   logic [Q_W-1:0]          q_in;
   logic [Q_W-1:0]          q_ff;
   logic [Q_W:0]            res_in;
   logic signed [OUT_W-1:0] out_ff;

   // Take magnitude, add half the divisor, drop the power of two
   always_comb begin
      ext   = SUM_W'(in_value);
      mag   = ext[SUM_W-1] ? (~ext + SUM_W'(1)) : ext;
      rnd   = mag + HALF;
      tq_in = rnd[SUM_W-1:SHIFT];
   end

   // Divide the rest by 5 through the reciprocal
   always_comb begin
      mul  = MUL_W'(tq_ff) * MUL_W'(RECIP);
      q_in = mul[MUL_W-1:T_W+3];
   end

   // Restore the sign
   always_comb begin
      res_in = neg_ff[1] ? (~{1'b0, q_ff} + (Q_W + 1)'(1)) : {1'b0, q_ff};
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[RDIV_LAT-2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      tq_ff     <= tq_in;
      neg_ff[0] <= in_value[IN_W-1];
      q_ff      <= q_in;
      neg_ff[1] <= neg_ff[0];
      out_ff    <= OUT_W'($signed(res_in));
   end

   assign out_valid = vld_ff[RDIV_LAT-1];
   assign out_value = out_ff;

endmodule

>>> design/spm_strip.sv
// One channel strip: level and CV gain, then linear pan into left and right shares.
module spm_strip #(
   parameter int SW = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [SW-1:0]            sample,
   input  logic [spm_pkg::STRIP_CFG_W-1:0] strip_cfg,
   input  logic [spm_pkg::CV_W-1:0]        level_cv,
   input  logic [spm_pkg::CV_W-1:0]        pan_cv,
   input  logic                            present,
   output logic                            out_valid,
   output logic signed [SW-1:0]            strip_out,
   output logic signed [SW+1:0]            left_out,
   output logic signed [SW+1:0]            right_out
);
   import spm_pkg::*;

   localparam int STRIP_W    = SW + 1;
   localparam int CONTRIB_W  = SW + 2;
   localparam int PROD_W     = SW + GAIN_W + 1;
   localparam int PAN_PROD_W = STRIP_W + CVC_W + 1;
   localparam int PAN_RAW_W  = CV_W + 2;
   localparam int PAN_DLY    = RDIV_LAT + 2;
   localparam int STRIP_DLY  = RDIV_LAT + 1;

   logic [LEVEL_W-1:0]          level;
   logic [LEVEL_W-1:0]          knob;
   logic [CVC_W-1:0]            cvc;
   logic [CVC_W-1:0]            knob5;
   logic [PAN_RAW_W-1:0]        pan_raw;
   logic [CVC_W-1:0]            pan_in;
   logic [GAIN_W-1:0]           gain_in;
   logic [GAIN_W-1:0]           gain_ff;
   logic signed [SW-1:0]        sample_ff;
   logic                        vld1_ff;
   logic                        vld2_ff;
   logic                        vld_pan_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic [CVC_W-1:0]            pan_ff [PAN_DLY];
   logic                        strip_vld;
   logic signed [STRIP_W-1:0]   strip_val;
   logic [CVC_W-1:0]            wl;
   logic signed [PAN_PROD_W-1:0] vl_in;
   logic signed [PAN_PROD_W-1:0] vr_in;
   logic signed [PAN_PROD_W-1:0] vl_ff;
   logic signed [PAN_PROD_W-1:0] vr_ff;
   logic signed [STRIP_W-1:0]   strip_dly_ff [STRIP_DLY];
   logic signed [STRIP_W-1:0]   strip_last;
   logic                        lvld;
   logic                        rvld;

   // Clamp knobs and CVs; pan position is 2 * pan CV + 5 * knob over 20480
   always_comb begin
      level   = clamp_knob(strip_cfg[15:0]);
      knob    = clamp_knob({3'b000, strip_cfg[STRIP_CFG_W-1:16]});
      cvc     = clamp_cv(level_cv);
      knob5   = {knob, 2'b00} + {2'b00, knob};
      pan_raw = {pan_cv[CV_W-1], pan_cv, 1'b0} + {3'b000, knob5};
      if (pan_raw[PAN_RAW_W-1]) begin
         pan_in = '0;
      end else if (pan_raw > PAN_RAW_W'(CV_FULL)) begin
         pan_in = CV_FULL;
      end else begin
         pan_in = pan_raw[CVC_W-1:0];
      end
      // Drop absent channels by zeroing their gain
      gain_in = present ? (GAIN_W'(level) * GAIN_W'(cvc)) : '0;
   end

   // Scale the sample by the combined gain
   assign prod_in = PROD_W'(sample_ff) * PROD_W'($signed({1'b0, gain_ff}));

   spm_rdiv5 #(
      .IN_W  (PROD_W),
      .SHIFT (STRIP_SHIFT),
      .OUT_W (STRIP_W)
   ) u_strip_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld2_ff),
      .in_value  (prod_ff),
      .out_valid (strip_vld),
      .out_value (strip_val)
   );

   // Split the strip into left and right shares
   always_comb begin
      wl    = CV_FULL - pan_ff[PAN_DLY-1];
      vl_in = PAN_PROD_W'(strip_val) * PAN_PROD_W'($signed({1'b0, wl}));
      vr_in = PAN_PROD_W'(strip_val) * PAN_PROD_W'($signed({1'b0, pan_ff[PAN_DLY-1]}));
   end

   spm_rdiv5 #(
      .IN_W  (PAN_PROD_W),
      .SHIFT (PAN_SHIFT),
      .OUT_W (CONTRIB_W)
   ) u_left_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_pan_ff),
      .in_value  (vl_ff),
      .out_valid (lvld),
      .out_value (left_out)
   );

   spm_rdiv5 #(
      .IN_W  (PAN_PROD_W),
      .SHIFT (PAN_SHIFT),
      .OUT_W (CONTRIB_W)
   ) u_right_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_pan_ff),
      .in_value  (vr_ff),
      .out_valid (rvld),
      .out_value (right_out)
   );

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld_pan_ff <= 1'b0;
      end else begin
         vld1_ff    <= in_valid;
         vld2_ff    <= vld1_ff;
         vld_pan_ff <= strip_vld;
      end
   end

   // Advance payload and the pan and strip delay lines
   always_ff @(posedge clock) begin
      sample_ff <= sample;
      gain_ff   <= gain_in;
      prod_ff   <= prod_in;
      vl_ff     <= vl_in;
      vr_ff     <= vr_in;
      pan_ff[0] <= pan_in;
      for (int i = 1; i < PAN_DLY; i++) begin
         pan_ff[i] <= pan_ff[i-1];
      end
      strip_dly_ff[0] <= strip_val;
      for (int i = 1; i < STRIP_DLY; i++) begin
         strip_dly_ff[i] <= strip_dly_ff[i-1];
      end
   end

   // Saturate the strip to the sample range
   always_comb begin
      strip_last = strip_dly_ff[STRIP_DLY-1];
      if (strip_last[STRIP_W-1] != strip_last[STRIP_W-2]) begin
         strip_out = strip_last[STRIP_W-1] ? {1'b1, {(SW-1){1'b0}}}
                                           : {1'b0, {(SW-1){1'b1}}};
      end else begin
         strip_out = strip_last[SW-1:0];
      end
   end

   assign out_valid = lvld & rvld;

endmodule

>>> design/spm_mix.sv
// Master bus: sum the channel shares, apply master knob and CV, saturate.
module spm_mix #(
   parameter int SW = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [spm_pkg::MASTER_CFG_W-1:0] master_cfg,
   input  logic [spm_pkg::CV_W-1:0]         master_cv,
   input  logic                             lane_valid,
   input  logic signed [SW+1:0]             lane_left  [spm_pkg::CHANNELS],
   input  logic signed [SW+1:0]             lane_right [spm_pkg::CHANNELS],
   output logic                             out_valid,
   output logic signed [SW-1:0]             mix_left,
   output logic signed [SW-1:0]             mix_right
);
   import spm_pkg::*;

   localparam int SUM_W  = SW + 2 + CH_W;
   localparam int MIXP_W = SUM_W + GAIN_W + 1;
   localparam int TOP_W  = SUM_W - SW + 1;

   logic [GAIN_W-1:0]        mg_in;
   logic [GAIN_W-1:0]        mg_ff [LANE_LAT];
   logic [GAIN_W-1:0]        mgx_ff;
   logic signed [SUM_W-1:0]  sum_l_in;
   logic signed [SUM_W-1:0]  sum_r_in;
   logic signed [SUM_W-1:0]  sum_l_ff;
   logic signed [SUM_W-1:0]  sum_r_ff;
   logic                     vld_sum_ff;
   logic                     vld_prod_ff;
   logic signed [MIXP_W-1:0] mp_l_ff;
   logic signed [MIXP_W-1:0] mp_r_ff;
   logic                     lvld;
   logic                     rvld;
   logic signed [SUM_W-1:0]  mix_l_val;
   logic signed [SUM_W-1:0]  mix_r_val;
   logic signed [SW-1:0]     mix_l_in;
   logic signed [SW-1:0]     mix_r_in;
   logic signed [SW-1:0]     mix_l_ff;
   logic signed [SW-1:0]     mix_r_ff;
   logic                     out_vld_ff;

   // Master gain from knob and clamped CV, taken at request time
   assign mg_in = GAIN_W'(clamp_knob({3'b000, master_cfg})) * GAIN_W'(clamp_cv(master_cv));

   // Sum the channel shares
   always_comb begin
      sum_l_in = '0;
      sum_r_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         sum_l_in = sum_l_in + SUM_W'(lane_left[i]);
         sum_r_in = sum_r_in + SUM_W'(lane_right[i]);
      end
   end

   spm_rdiv5 #(
      .IN_W  (MIXP_W),
      .SHIFT (STRIP_SHIFT),
      .OUT_W (SUM_W)
   ) u_left_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_prod_ff),
      .in_value  (mp_l_ff),
      .out_valid (lvld),
      .out_value (mix_l_val)
   );

   spm_rdiv5 #(
      .IN_W  (MIXP_W),
      .SHIFT (STRIP_SHIFT),
      .OUT_W (SUM_W)
   ) u_right_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_prod_ff),
      .in_value  (mp_r_ff),
      .out_valid (rvld),
      .out_value (mix_r_val)
   );

   // Saturate both mixes to the sample range
   always_comb begin
      if ((&mix_l_val[SUM_W-1:SW-1]) | ~(|mix_l_val[SUM_W-1:SW-1])) begin
         mix_l_in = mix_l_val[SW-1:0];
      end else begin
         mix_l_in = mix_l_val[SUM_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end
      if ((&mix_r_val[SUM_W-1:SW-1]) | ~(|mix_r_val[SUM_W-1:SW-1])) begin
         mix_r_in = mix_r_val[SW-1:0];
      end else begin
         mix_r_in = mix_r_val[SUM_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_sum_ff  <= 1'b0;
         vld_prod_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         vld_sum_ff  <= lane_valid;
         vld_prod_ff <= vld_sum_ff;
         out_vld_ff  <= lvld & rvld;
      end
   end

   // Hold master gain in step with the lanes, then scale the sums
   always_ff @(posedge clock) begin
      mg_ff[0] <= mg_in;
      for (int i = 1; i < LANE_LAT; i++) begin
         mg_ff[i] <= mg_ff[i-1];
      end
      sum_l_ff <= sum_l_in;
      sum_r_ff <= sum_r_in;
      mgx_ff   <= mg_ff[LANE_LAT-1];
      mp_l_ff  <= MIXP_W'(sum_l_ff) * MIXP_W'($signed({1'b0, mgx_ff}));
      mp_r_ff  <= MIXP_W'(sum_r_ff) * MIXP_W'($signed({1'b0, mgx_ff}));
      mix_l_ff <= mix_l_in;
      mix_r_ff <= mix_r_in;
   end

   assign out_valid = out_vld_ff;
   assign mix_left  = mix_l_ff;
   assign mix_right = mix_r_ff;

   // Top bits checked for overflow span the sign and all guard bits
   if (TOP_W < 2) begin : g_bad_width
      $error("sum width too small");
   end

endmodule

>>> sim/four_channel_stereo_pan_mixer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the four channel stereo pan mixer: bursty requests, scoreboard.
module four_channel_stereo_pan_mixer_tb;
   import spm_pkg::*;

   localparam int     SW               = SAMPLE_WIDTH_DEF;
   localparam int     CLK_PERIOD       = 8;
   localparam int     RESET_CYCLES     = 12;
   localparam int     RUN_LIMIT_NS     = 2_000_000;
   localparam int     RANDOM_PHASES    = 10;
   localparam int     FRAMES_PER_PHASE = 103;
   localparam longint UNITY_L          = UNITY;
   localparam longint FULL_L           = CV_FULL;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_BASE  = '0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_MASTER + 1'b1;

   typedef enum {GAIN_UNITY, GAIN_MAX, GAIN_ZERO, GAIN_RIGHT, GAIN_RANDOM} gain_mode_type;

   typedef struct packed {
      logic [CHANNELS-1:0][SW-1:0] sample;
      logic [PACK_W-1:0]           level_cvs;
      logic [PACK_W-1:0]           pan_cvs;
      logic [CHANNELS-1:0]         present;
      logic [CV_W-1:0]             master_cv;
   } frame_type;

   typedef struct packed {
      logic [SW-1:0]               left;
      logic [SW-1:0]               right;
      logic [CHANNELS-1:0][SW-1:0] strip;
   } mix_type;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    start            = 1'b0;
   logic                    busy;
   logic signed [SW-1:0]    req_sample_0     = '0;
   logic signed [SW-1:0]    req_sample_1     = '0;
   logic signed [SW-1:0]    req_sample_2     = '0;
   logic signed [SW-1:0]    req_sample_3     = '0;
   logic [PACK_W-1:0]       req_level_cvs    = '0;
   logic [PACK_W-1:0]       req_pan_cvs      = '0;
   logic [CHANNELS-1:0]     req_present_mask = '0;
   logic signed [CV_W-1:0]  req_master_cv    = '0;
   logic                    rsp_strobe;
   logic signed [SW-1:0]    rsp_mix_left;
   logic signed [SW-1:0]    rsp_mix_right;
   logic signed [SW-1:0]    rsp_strip_out_0;
   logic signed [SW-1:0]    rsp_strip_out_1;
   logic signed [SW-1:0]    rsp_strip_out_2;
   logic signed [SW-1:0]    rsp_strip_out_3;
   logic                    csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index        = '0;
   logic [CSR_W-1:0]        csr_wdata        = '0;

   // Gain registers as the mixer should hold them
   logic [STRIP_CFG_W-1:0]  strip_cfg [CHANNELS];
   logic [MASTER_CFG_W-1:0] master_cfg;

   frame_type frames_to_send [$];
   mix_type   mix_expect_q [$];
   frame_type frame_on_port;
   int        frames_queued = 0;
   int        frames_taken  = 0;
   int        results_seen  = 0;
   int        mismatches    = 0;
   int        gain_settings = 0;
   int        burst_left    = 0;
   int        gap_left      = 0;

   four_channel_stereo_pan_mixer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_0     (req_sample_0),
      .req_sample_1     (req_sample_1),
      .req_sample_2     (req_sample_2),
      .req_sample_3     (req_sample_3),
      .req_level_cvs    (req_level_cvs),
      .req_pan_cvs      (req_pan_cvs),
      .req_present_mask (req_present_mask),
      .req_master_cv    (req_master_cv),
      .rsp_strobe       (rsp_strobe),
      .rsp_mix_left     (rsp_mix_left),
      .rsp_mix_right    (rsp_mix_right),
      .rsp_strip_out_0  (rsp_strip_out_0),
      .rsp_strip_out_1  (rsp_strip_out_1),
      .rsp_strip_out_2  (rsp_strip_out_2),
      .rsp_strip_out_3  (rsp_strip_out_3),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Divide with rounding to nearest, ties away from zero
   function automatic longint round_div(input longint num, input longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [SW-1:0] saturate(input longint v);
      return SW'(clip(v, -(longint'(1) << (SW - 1)), (longint'(1) << (SW - 1)) - 1));
   endfunction

   // Compute the strip outputs and the stereo mix of one frame
   function automatic mix_type predict_mix(input frame_type f);
      mix_type r;
      longint  level, knob, cvc, pos, strip, sum_l, sum_r, mgain, mcvc;
      sum_l = 0;
      sum_r = 0;
      mgain = clip(longint'(master_cfg), 0, UNITY_L);
      mcvc  = clip(longint'($signed(f.master_cv)), 0, FULL_L);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (!f.present[ch]) begin
            r.strip[ch] = '0;
         end else begin
            level = clip(longint'(strip_cfg[ch][15:0]), 0, UNITY_L);
            knob  = clip(longint'(strip_cfg[ch][28:16]), 0, UNITY_L);
            cvc   = clip(longint'($signed(f.level_cvs[CV_W*ch +: CV_W])), 0, FULL_L);
            strip = round_div(longint'($signed(f.sample[ch])) * level * cvc,
                              UNITY_L * FULL_L);
            // pan CV / 5 V plus the knob, in units of 1 / 20480
            pos   = clip(2 * longint'($signed(f.pan_cvs[CV_W*ch +: CV_W])) + 5 * knob,
                         0, FULL_L);
            sum_l += round_div(strip * (FULL_L - pos), FULL_L / 2);
            sum_r += round_div(strip * pos, FULL_L / 2);
            r.strip[ch] = saturate(strip);
         end
      end
      r.left  = saturate(round_div(sum_l * mgain * mcvc, UNITY_L * FULL_L));
      r.right = saturate(round_div(sum_r * mgain * mcvc, UNITY_L * FULL_L));
      return r;
   endfunction

   // Unpatched CVs, every channel present, silence
   function automatic frame_type base_frame();
      frame_type f;
      f.sample    = '0;
      f.level_cvs = {CHANNELS{LEVEL_CV_OPEN}};
      f.pan_cvs   = {CHANNELS{PAN_CV_OPEN}};
      f.present   = '1;
      f.master_cv = LEVEL_CV_OPEN;
      return f;
   endfunction

   function automatic logic [SW-1:0] random_sample();
      case ($urandom_range(0, 5))
         0:       return {1'b0, {(SW-1){1'b1}}};
         1:       return {1'b1, {(SW-1){1'b0}}};
         2:       return SW'($signed($urandom_range(0, 512)) - 256);
         default: return SW'($urandom);
      endcase
   endfunction

   // Gain CV: mostly in range, with unpatched, negative and over-range values
   function automatic logic [CV_W-1:0] random_gain_cv();
      case ($urandom_range(0, 7))
         0:       return LEVEL_CV_OPEN;
         1:       return '0;
         2:       return CV_W'($urandom) | 16'h8000;
         3:       return CV_W'($urandom_range(20481, 32767));
         4:       return CV_W'($urandom);
         default: return CV_W'($urandom_range(0, 20480));
      endcase
   endfunction

   function automatic logic [CV_W-1:0] random_pan_cv();
      case ($urandom_range(0, 6))
         0:       return PAN_CV_OPEN;
         1:       return CV_W'($urandom);
         2:       return 16'h7FFF;
         3:       return 16'h8000;
         4:       return CV_W'(-$signed($urandom_range(0, 10240)));
         default: return CV_W'($urandom_range(0, 10240));
      endcase
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         f.sample[ch]                     = random_sample();
         f.level_cvs[CV_W*ch +: CV_W]     = random_gain_cv();
         f.pan_cvs[CV_W*ch +: CV_W]       = random_pan_cv();
      end
      f.present   = ($urandom_range(0, 2) == 0) ? CHANNELS'($urandom) : '1;
      f.master_cv = random_gain_cv();
      return f;
   endfunction

   // Knob value: mostly 0..unity, sometimes above unity where it must saturate
   function automatic longint random_knob(input longint top);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return UNITY_L;
         2:       return $urandom_range(UNITY_L + 1, top);
         default: return $urandom_range(0, UNITY_L);
      endcase
   endfunction

   task automatic queue_frame(input frame_type f);
      frames_to_send.push_back(f);
      frames_queued++;
   endtask

   // Hold until every request is taken and answered, then let the pipeline empty
   task automatic settle();
      while (frames_taken != frames_queued || mix_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (RSP_LAT + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < CSR_MASTER) begin
         strip_cfg[idx - CSR_STRIP_BASE] = val[STRIP_CFG_W-1:0];
      end else if (idx == CSR_MASTER) begin
         master_cfg = val[MASTER_CFG_W-1:0];
      end
   endtask

   task automatic configure(input gain_mode_type mode);
      logic [CSR_W-1:0] val;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         // pan knob in the upper bits, level knob in the lower 16
         case (mode)
            GAIN_UNITY:  val = {13'd2048, 16'd4096};
            GAIN_MAX:    val = {13'h1FFF, 16'hFFFF};
            GAIN_ZERO:   val = '0;
            GAIN_RIGHT:  val = {13'd4096, 16'd4096};
            default:     val = {13'(random_knob(8191)), 16'(random_knob(65535))};
         endcase
         write_reg(CSR_STRIP_BASE + CSR_IDX_W'(ch), val);
      end
      // upper bits above the master field are junk the block must drop
      case (mode)
         GAIN_MAX:    val = '1;
         GAIN_ZERO:   val = '0;
         GAIN_RANDOM: val = {16'($urandom), 13'(random_knob(8191))};
         default:     val = CSR_W'(UNITY);
      endcase
      write_reg(CSR_MASTER, val);
      // writes to unused indexes must leave every gain alone
      write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, (1 << CSR_IDX_W) - 1)),
                CSR_W'($urandom));
      gain_settings++;
   endtask

   // Drive requests in bursts with random gaps; record each accepted request
   always @(posedge clock) begin : drive_requests
      frame_type f;
      logic      launch;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            mix_expect_q.push_back(predict_mix(frame_on_port));
            frames_taken++;
            if (burst_left > 0) begin
               burst_left--;
            end
         end
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         launch = 1'b0;
         f      = random_frame();
         if (gap_left > 0) begin
            gap_left--;
         end else if (frames_to_send.size() > 0) begin
            launch = 1'b1;
            f      = frames_to_send.pop_front();
         end
         frame_on_port     = f;
         start            <= launch;
         req_sample_0     <= f.sample[0];
         req_sample_1     <= f.sample[1];
         req_sample_2     <= f.sample[2];
         req_sample_3     <= f.sample[3];
         req_level_cvs    <= f.level_cvs;
         req_pan_cvs      <= f.pan_cvs;
         req_present_mask <= f.present;
         req_master_cv    <= f.master_cv;
      end
   end

   task automatic check_field(input string field, input logic [SW-1:0] want,
                              input logic [SW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
         mismatches++;
      end
   endtask

   // Compare each strobed result with the oldest prediction
   always @(posedge clock) begin : check_results
      mix_type want;
      if (!reset && $isunknown(rsp_strobe)) begin
         $error("rsp_strobe: expected 0 or 1, got %b", rsp_strobe);
         mismatches++;
      end else if (!reset && rsp_strobe) begin
         results_seen++;
         if (mix_expect_q.size() == 0) begin
            $error("rsp_strobe: expected no result, got one");
            mismatches++;
         end else begin
            want = mix_expect_q.pop_front();
            check_field("mix_left", want.left, rsp_mix_left);
            check_field("mix_right", want.right, rsp_mix_right);
            check_field("strip_out_0", want.strip[0], rsp_strip_out_0);
            check_field("strip_out_1", want.strip[1], rsp_strip_out_1);
            check_field("strip_out_2", want.strip[2], rsp_strip_out_2);
            check_field("strip_out_3", want.strip[3], rsp_strip_out_3);
         end
      end
   end

   initial begin : run_phases
      frame_type f;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         strip_cfg[ch] = STRIP_CFG_RESET;
      end
      master_cfg = MASTER_CFG_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset gains: level knobs at zero silence every strip
      f        = base_frame();
      f.sample = {CHANNELS{16'h7FFF}};
      queue_frame(f);
      queue_frame(random_frame());
      queue_frame(random_frame());
      settle();

      configure(GAIN_UNITY);
      // absent channels add nothing, full scale saturates both mixes
      f         = base_frame();
      f.sample  = {CHANNELS{16'h7FFF}};
      f.present = '0;
      queue_frame(f);
      f.present = '1;
      queue_frame(f);
      f.sample  = {CHANNELS{16'h8000}};
      queue_frame(f);
      // lone channel passes straight through at centered pan
      f           = base_frame();
      f.sample[0] = 16'd1000;
      f.present   = 4'b0001;
      queue_frame(f);
      // pan CV hard left, then hard right
      f                          = base_frame();
      f.sample[1]                = 16'd3000;
      f.present                  = 4'b0010;
      f.pan_cvs[CV_W*1 +: CV_W]  = 16'h8000;
      queue_frame(f);
      f                          = base_frame();
      f.sample[2]                = -16'sd3000;
      f.present                  = 4'b0100;
      f.pan_cvs[CV_W*2 +: CV_W]  = 16'h7FFF;
      queue_frame(f);
      // negative level CV mutes, level CV above 10 V clamps
      f                            = base_frame();
      f.sample                     = {CHANNELS{16'd12345}};
      f.level_cvs[CV_W*3 +: CV_W]  = 16'h8000;
      queue_frame(f);
      f.level_cvs = {CHANNELS{16'h7FFF}};
      queue_frame(f);
      // half level CV on odd samples lands on rounding ties
      f           = base_frame();
      f.level_cvs = {CHANNELS{16'd10240}};
      f.sample    = {16'hFFFD, 16'd3, 16'hFFFF, 16'd1};
      queue_frame(f);
      // master CV below zero mutes, above 10 V clamps
      f           = base_frame();
      f.sample    = {CHANNELS{16'd2000}};
      f.master_cv = 16'h8000;
      queue_frame(f);
      f.master_cv = 16'h7FFF;
      queue_frame(f);
      // half master CV rounds single codes away from zero
      f           = base_frame();
      f.master_cv = 16'd10240;
      f.sample[0] = 16'd1;
      f.present   = 4'b0001;
      queue_frame(f);
      f.sample[0] = 16'hFFFF;
      queue_frame(f);
      // smallest pan CV step off center
      f                          = base_frame();
      f.sample[0]                = 16'd5120;
      f.present                  = 4'b0001;
      f.pan_cvs[CV_W*0 +: CV_W]  = 16'd1;
      queue_frame(f);
      settle();

      // random frames under extreme, then random, gain settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       configure(GAIN_MAX);
            1:       configure(GAIN_ZERO);
            2:       configure(GAIN_RIGHT);
            default: configure(GAIN_RANDOM);
         endcase
         repeat (FRAMES_PER_PHASE) queue_frame(random_frame());
         settle();
      end

      $display("Checked %0d results from %0d requests under %0d gain settings.",
               results_seen, frames_taken, gain_settings + 1);
      $display("Covered absent channels, clamped CVs and knobs, hard pans, ties, saturation.");
      if (mismatches == 0) begin
         $display("four_channel_stereo_pan_mixer_tb OK");
      end else begin
         $display("four_channel_stereo_pan_mixer_tb NOT OK");
      end
      $finish;
   end

   // Abort a hung run
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Run limit reached with %0d results outstanding.", mix_expect_q.size());
      $display("four_channel_stereo_pan_mixer_tb NOT OK");
      $finish;
   end

endmodule
